/* rtl/b3sh_pkg.sv */
// Package: shared types, constants and functions of the BLAKE3 stream hasher.
`default_nettype none
package b3sh_pkg;

  localparam int unsigned TreeDepth  = 54;
  localparam int unsigned StackSlots = TreeDepth + 1;
  localparam int unsigned StackAw    = $clog2(StackSlots);
  localparam int unsigned StackLvlW  = $clog2(StackSlots + 1);

  localparam logic [31:0] FlagChunkStart = 32'd1;
  localparam logic [31:0] FlagChunkEnd   = 32'd2;
  localparam logic [31:0] FlagParent     = 32'd4;
  localparam logic [31:0] FlagRoot       = 32'd8;

  localparam logic [6:0] BlockBytes    = 7'd64;
  localparam logic [4:0] LastBlockIdx  = 5'd15;
  localparam logic [4:0] DigestDefault = 5'd8;
  localparam logic [4:0] DigestMax     = 5'd16;
  localparam logic [2:0] RoundLast     = 3'd6;
  localparam logic [2:0] MixLast       = 3'd7;

  typedef logic [7:0][31:0]  cv_t;
  typedef logic [15:0][31:0] blk_t;

  localparam cv_t InitVec = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_BLK_CMP,
    ST_CHUNK_CMP,
    ST_MERGE_RD,
    ST_MERGE_CMP,
    ST_PUSH,
    ST_FIN_CMP,
    ST_FOLD_RD,
    ST_FOLD_CMP,
    ST_ROOT_CMP,
    ST_EMIT
  } state_e;

  // Request to the compression engine.
  typedef struct packed {
    logic        start;
    cv_t         cv;
    blk_t        msg;
    logic [63:0] ctr;
    logic [31:0] len;
    logic [31:0] flags;
  } cmp_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0][31:0] v;
  } cmp_rsp_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Message word permutation applied after each round.
  function automatic blk_t permute(blk_t m);
    blk_t t;
    t[0] = m[2];  t[1] = m[6];  t[2] = m[3];   t[3] = m[10];
    t[4] = m[7];  t[5] = m[0];  t[6] = m[4];   t[7] = m[13];
    t[8] = m[1];  t[9] = m[11]; t[10] = m[12]; t[11] = m[5];
    t[12] = m[9]; t[13] = m[14]; t[14] = m[15]; t[15] = m[8];
    permute = t;
  endfunction

endpackage
`default_nettype wire

/* rtl/b3sh_compress.sv */
// Compression engine: one shared G function applied eight times per round.
`default_nettype none
module b3sh_compress (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b3sh_pkg::cmp_req_t  req_i,
  output b3sh_pkg::cmp_rsp_t       rsp_o
);

  logic [15:0][31:0] v_q, v_d;
  b3sh_pkg::blk_t    m_q, m_d;
  logic [2:0]        rnd_q, rnd_d;
  logic [2:0]        mix_q, mix_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [3:0] ia, ib, ic, id;
  logic [31:0] x, y, a1, d1, c1, b1, a2, d2, c2, b2;

  always_comb begin
    case (mix_q)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    x  = m_q[{mix_q, 1'b0}];
    y  = m_q[{mix_q, 1'b1}];
    a1 = v_q[ia] + v_q[ib] + x;
    d1 = b3sh_pkg::rotr(v_q[id] ^ a1, 16);
    c1 = v_q[ic] + d1;
    b1 = b3sh_pkg::rotr(v_q[ib] ^ c1, 12);
    a2 = a1 + b1 + y;
    d2 = b3sh_pkg::rotr(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = b3sh_pkg::rotr(b1 ^ c2, 7);
  end

  always_comb begin
    v_d    = v_q;
    m_d    = m_q;
    rnd_d  = rnd_q;
    mix_d  = mix_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      v_d[7:0]  = req_i.cv;
      v_d[11:8] = b3sh_pkg::InitVec[3:0];
      v_d[12]   = req_i.ctr[31:0];
      v_d[13]   = req_i.ctr[63:32];
      v_d[14]   = req_i.len;
      v_d[15]   = req_i.flags;
      m_d       = req_i.msg;
      rnd_d     = '0;
      mix_d     = '0;
      busy_d    = 1'b1;
    end else if (busy_q) begin
      v_d[ia] = a2;
      v_d[ib] = b2;
      v_d[ic] = c2;
      v_d[id] = d2;
      mix_d   = mix_q + 3'd1;
      if (mix_q == b3sh_pkg::MixLast) begin
        m_d   = b3sh_pkg::permute(m_q);
        rnd_d = rnd_q + 3'd1;
        if (rnd_q == b3sh_pkg::RoundLast) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      mix_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
      mix_q  <= mix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    m_q <= m_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.v    = v_q;

endmodule
`default_nettype wire

/* rtl/b3sh_stack.sv */
// Subtree chaining value stack memory with registered read.
`default_nettype none
module b3sh_stack (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [b3sh_pkg::StackAw-1:0]  waddr_i,
  input  wire b3sh_pkg::cv_t                 wdata_i,
  input  wire logic [b3sh_pkg::StackAw-1:0]  raddr_i,
  output b3sh_pkg::cv_t                      rdata_o
);

  b3sh_pkg::cv_t mem_q [b3sh_pkg::StackSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/blake3_stream_hasher_unit.sv */
// Top level of the BLAKE3 stream hasher: sequencer, chunk state and digest output.
//
// Usage: message words arrive on the input channel (data_word_i, valid_bytes_i,
// last_word_i) with in_valid_i / in_stall_o; a beat is taken at a clock edge
// where valid is high and stall is low. The block stalls its input while a word
// is being worked on. Its valid bytes are absorbed one at a time before the next
// beat is taken; a byte that follows a full block first costs one compression
// of 7 rounds x 8 G steps in the single shared G unit. A chunk close compresses
// the last block, then one parent compression per subtree merge, then a push. On
// a last word the stack is folded level by level, the root is compressed and
// digest_words beats leave on the output channel (out_valid_o / out_stall_i),
// one per cycle while not stalled. A stalled output beat holds its payload; the
// block waits with it. The digest_words register is written through cfg_we_i /
// cfg_data_i; the user must write it only while idle, which the block does not
// enforce. Values 0 and above 16 act as 1 and 16.
// Reset: state returns to the BLAKE3 IV, empty buffer, chunk count and stack
// level zero, digest_words 8. The stack memory needs no clearing: an entry is
// only read after it has been written. After the last digest beat the block
// returns to that initial state (the register keeps its value).
`default_nettype none
module blake3_stream_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic             last_digest_word_o
);

  localparam int unsigned Aw = b3sh_pkg::StackAw;
  localparam int unsigned Lw = b3sh_pkg::StackLvlW;

  b3sh_pkg::state_e state_q, state_d;

  logic [4:0]         dw_q;
  b3sh_pkg::cv_t      cv_q, cv_d;
  b3sh_pkg::blk_t     buf_q, buf_d;
  logic [6:0]         nbuf_q, nbuf_d;
  logic [4:0]         nblk_q, nblk_d;
  logic [63:0]        ctr_q, ctr_d;
  logic [63:0]        tot_q, tot_d;
  logic [Lw-1:0]      lvl_q, lvl_d;
  logic [31:0]        word_q, word_d;
  logic [2:0]         left_q, left_d;
  logic               last_q, last_d;
  // Final-node parameters and the kept cv for output words 8..15.
  b3sh_pkg::cv_t      fcv_q, fcv_d;
  b3sh_pkg::blk_t     fblk_q, fblk_d;
  logic [31:0]        flen_q, flen_d;
  logic [31:0]        fflg_q, fflg_d;
  logic [15:0][31:0]  dig_q, dig_d;
  logic [4:0]         oidx_q, oidx_d;
  logic [4:0]         ocnt_q, ocnt_d;

  b3sh_pkg::cmp_req_t req;
  b3sh_pkg::cmp_rsp_t rsp;
  b3sh_pkg::cv_t      out_cv, stk_rd;
  logic               stk_we;
  logic [Aw-1:0]      stk_waddr, stk_raddr;
  logic [Lw-1:0]      lvl_dec;
  logic [31:0]        start_flag;

  b3sh_compress u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  b3sh_stack u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (cv_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      out_cv[i] = rsp.v[i] ^ rsp.v[i+8];
    end
  end

  assign start_flag = (nblk_q == '0) ? b3sh_pkg::FlagChunkStart : 32'd0;
  assign lvl_dec    = lvl_q - Lw'(1);
  assign stk_raddr  = lvl_dec[Aw-1:0];
  assign stk_waddr  = lvl_q[Aw-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      b3sh_pkg::ST_IDLE:
        if (in_valid_i) state_d = b3sh_pkg::ST_ABSORB;
      b3sh_pkg::ST_ABSORB:
        if (left_q != '0) begin
          if (nbuf_q >= b3sh_pkg::BlockBytes) begin
            state_d = (nblk_q >= b3sh_pkg::LastBlockIdx) ? b3sh_pkg::ST_CHUNK_CMP
                                                          : b3sh_pkg::ST_BLK_CMP;
          end
        end else if (last_q) begin
          state_d = b3sh_pkg::ST_FIN_CMP;
        end else begin
          state_d = b3sh_pkg::ST_IDLE;
        end
      b3sh_pkg::ST_BLK_CMP:
        if (rsp.done) state_d = b3sh_pkg::ST_ABSORB;
      b3sh_pkg::ST_CHUNK_CMP:
        if (rsp.done) begin
          state_d = (!tot_q[0] && lvl_q != '0) ? b3sh_pkg::ST_MERGE_RD : b3sh_pkg::ST_PUSH;
        end
      b3sh_pkg::ST_MERGE_RD:
        state_d = b3sh_pkg::ST_MERGE_CMP;
      b3sh_pkg::ST_MERGE_CMP:
        if (rsp.done) begin
          state_d = (!tot_q[0] && lvl_q != '0) ? b3sh_pkg::ST_MERGE_RD : b3sh_pkg::ST_PUSH;
        end
      b3sh_pkg::ST_PUSH:
        state_d = b3sh_pkg::ST_ABSORB;
      b3sh_pkg::ST_FIN_CMP:
        if (lvl_q == '0) state_d = b3sh_pkg::ST_ROOT_CMP;
        else if (rsp.done) state_d = b3sh_pkg::ST_FOLD_RD;
      b3sh_pkg::ST_FOLD_RD:
        state_d = b3sh_pkg::ST_FOLD_CMP;
      b3sh_pkg::ST_FOLD_CMP:
        if (lvl_q == '0) state_d = b3sh_pkg::ST_ROOT_CMP;
        else if (rsp.done) state_d = b3sh_pkg::ST_FOLD_RD;
      b3sh_pkg::ST_ROOT_CMP:
        if (rsp.done) state_d = b3sh_pkg::ST_EMIT;
      b3sh_pkg::ST_EMIT:
        if (!out_stall_i && oidx_q + 5'd1 == ocnt_q) state_d = b3sh_pkg::ST_IDLE;
      default:
        state_d = b3sh_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cv_d   = cv_q;   buf_d  = buf_q;   nbuf_d = nbuf_q; nblk_d = nblk_q;
    ctr_d  = ctr_q;  tot_d  = tot_q;   lvl_d  = lvl_q;  word_d = word_q;
    left_d = left_q; last_d = last_q;  fcv_d  = fcv_q;  fblk_d = fblk_q;
    flen_d = flen_q; fflg_d = fflg_q;  dig_d  = dig_q;
    oidx_d = oidx_q; ocnt_d = ocnt_q;
    stk_we = 1'b0;
    req.start = 1'b0;
    req.cv    = cv_q;
    req.msg   = buf_q;
    req.ctr   = ctr_q;
    req.len   = 32'd64;
    req.flags = start_flag;
    in_stall_o = (state_q != b3sh_pkg::ST_IDLE);
    case (state_q)
      b3sh_pkg::ST_IDLE:
        if (in_valid_i) begin
          word_d = data_word_i;
          left_d = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
          last_d = last_word_i;
        end
      b3sh_pkg::ST_ABSORB:
        if (left_q != '0) begin
          if (nbuf_q >= b3sh_pkg::BlockBytes) begin
            req.start = 1'b1;
            if (nblk_q >= b3sh_pkg::LastBlockIdx) begin
              req.flags = start_flag | b3sh_pkg::FlagChunkEnd;
              tot_d     = ctr_q + 64'd1;
            end
          end else begin
            buf_d[nbuf_q[5:2]][nbuf_q[1:0]*8 +: 8] = word_q[7:0];
            nbuf_d = nbuf_q + 7'd1;
            word_d = word_q >> 8;
            left_d = left_q - 3'd1;
          end
        end else if (last_q) begin
          fcv_d  = cv_q;
          fblk_d = buf_q;
          flen_d = {25'd0, nbuf_q};
          fflg_d = start_flag | b3sh_pkg::FlagChunkEnd;
          if (lvl_q != '0) begin
            req.start = 1'b1;
            req.len   = {25'd0, nbuf_q};
            req.flags = start_flag | b3sh_pkg::FlagChunkEnd;
          end
        end
      b3sh_pkg::ST_BLK_CMP:
        if (rsp.done) begin
          cv_d   = out_cv;
          nblk_d = nblk_q + 5'd1;
          buf_d  = '0;
          nbuf_d = '0;
        end
      b3sh_pkg::ST_CHUNK_CMP, b3sh_pkg::ST_MERGE_CMP:
        if (rsp.done) begin
          cv_d = out_cv;
          if (!tot_q[0] && lvl_q != '0) begin
            lvl_d = lvl_dec;
          end
        end
      b3sh_pkg::ST_MERGE_RD: begin
        req.start = 1'b1;
        req.cv    = b3sh_pkg::InitVec;
        req.msg   = {cv_q, stk_rd};
        req.ctr   = '0;
        req.flags = b3sh_pkg::FlagParent;
        tot_d     = tot_q >> 1;
      end
      b3sh_pkg::ST_PUSH: begin
        if (lvl_q < Lw'(b3sh_pkg::StackSlots)) begin
          stk_we = 1'b1;
          lvl_d  = lvl_q + Lw'(1);
        end
        ctr_d  = ctr_q + 64'd1;
        cv_d   = b3sh_pkg::InitVec;
        buf_d  = '0;
        nbuf_d = '0;
        nblk_d = '0;
      end
      b3sh_pkg::ST_FIN_CMP, b3sh_pkg::ST_FOLD_CMP:
        if (lvl_q == '0) begin
          req.start = 1'b1;
          req.cv    = fcv_q;
          req.msg   = fblk_q;
          req.len   = flen_q;
          req.ctr   = '0;
          req.flags = fflg_q | b3sh_pkg::FlagRoot;
        end else if (rsp.done) begin
          fcv_d = out_cv;
          lvl_d = lvl_dec;
        end
      b3sh_pkg::ST_FOLD_RD: begin
        fblk_d = {fcv_q, stk_rd};
        fcv_d  = b3sh_pkg::InitVec;
        flen_d = 32'd64;
        fflg_d = b3sh_pkg::FlagParent;
        if (lvl_q != '0) begin
          req.start = 1'b1;
          req.cv    = b3sh_pkg::InitVec;
          req.msg   = {fcv_q, stk_rd};
          req.ctr   = '0;
          req.flags = b3sh_pkg::FlagParent;
        end
      end
      b3sh_pkg::ST_ROOT_CMP:
        if (rsp.done) begin
          for (int i = 0; i < 8; i++) begin
            dig_d[i]   = rsp.v[i] ^ rsp.v[i+8];
            dig_d[i+8] = rsp.v[i+8] ^ fcv_q[i];
          end
          oidx_d = '0;
          ocnt_d = (dw_q == '0) ? 5'd1
                 : (dw_q > b3sh_pkg::DigestMax) ? b3sh_pkg::DigestMax : dw_q;
        end
      b3sh_pkg::ST_EMIT:
        if (!out_stall_i) begin
          oidx_d = oidx_q + 5'd1;
          if (oidx_q + 5'd1 == ocnt_q) begin
            cv_d   = b3sh_pkg::InitVec;
            buf_d  = '0;
            nbuf_d = '0;
            nblk_d = '0;
            ctr_d  = '0;
            lvl_d  = '0;
          end
        end
      default: ;
    endcase
  end

  // A fold step reads the stack at the level below; issue the compress after
  // the read, so the fold read state launches the parent compression itself; the
  // fold compress state waits for its result, or at level zero starts the root.

  assign out_valid_o        = (state_q == b3sh_pkg::ST_EMIT);
  assign digest_word_o      = dig_q[oidx_q[3:0]];
  assign last_digest_word_o = (oidx_q + 5'd1 == ocnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b3sh_pkg::ST_IDLE;
      dw_q    <= b3sh_pkg::DigestDefault;
      cv_q    <= b3sh_pkg::InitVec;
      buf_q   <= '0;
      nbuf_q  <= '0;
      nblk_q  <= '0;
      ctr_q   <= '0;
      lvl_q   <= '0;
      left_q  <= '0;
      last_q  <= 1'b0;
      oidx_q  <= '0;
      ocnt_q  <= 5'd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dw_q <= cfg_data_i;
      cv_q    <= cv_d;
      buf_q   <= buf_d;
      nbuf_q  <= nbuf_d;
      nblk_q  <= nblk_d;
      ctr_q   <= ctr_d;
      lvl_q   <= lvl_d;
      left_q  <= left_d;
      last_q  <= last_d;
      oidx_q  <= oidx_d;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q  <= tot_d;
    word_q <= word_d;
    fcv_q  <= fcv_d;
    fblk_q <= fblk_d;
    flen_q <= flen_d;
    fflg_q <= fflg_d;
    dig_q  <= dig_d;
  end

  // Keep the block from taking a beat while work is pending.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != b3sh_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  // Hold the output beat while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest beat changed");

  a_buf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbuf_q <= b3sh_pkg::BlockBytes)
    else $error("block buffer overfilled");

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= Lw'(b3sh_pkg::StackSlots))
    else $error("stack level out of range");

endmodule
`default_nettype wire

/* tb/sv/blake3_stream_hasher_unit_tb.sv */
// Testbench of the BLAKE3 stream hasher: directed and random messages checked against a predictor.
`timescale 1ns / 1ps
module blake3_stream_hasher_unit_tb;

  typedef logic [31:0] w8_t [8];
  typedef logic [31:0] w16_t [16];

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  // One row of the directed table; reg_val < 0 leaves the register alone.
  typedef struct {
    int          reg_val;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } stim_row_t;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        last_digest_word_o;

  blake3_stream_hasher_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_word_i        (data_word_i),
    .valid_bytes_i      (valid_bytes_i),
    .last_word_i        (last_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .digest_word_o      (digest_word_o),
    .last_digest_word_o (last_digest_word_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: a shadow of the hasher's chunk state and subtree stack.
  logic [31:0] hash_cv [8];
  logic [31:0] msg_buf [16];
  int unsigned buf_fill;
  int unsigned blk_cnt;
  logic [63:0] chunk_idx;
  logic [31:0] tree_vals [b3sh_pkg::StackSlots*8];
  int unsigned cv_depth;
  logic [4:0]  out_words_reg;

  digest_beat_t digest_q [$];
  int          err_cnt = 0;
  bit          calm = 1'b0;   // set for a stretch of messages with no random input idling or output stalls
  bit          beat_moved;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Seven rounds of the BLAKE3 compression; yields the full 16-word state.
  function automatic w16_t b3_compress(w8_t cv, w16_t msg, logic [31:0] len,
                                       logic [63:0] ctr, logic [31:0] fl);
    w16_t v;
    w16_t m;
    w16_t t;
    int ia [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
    int ib [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
    int ic [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
    int id [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
    int pm [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
    int a, b, c, d;
    m = msg;
    for (int i = 0; i < 8; i++) begin
      v[i] = cv[i];
      v[i+8] = b3sh_pkg::InitVec[i];
    end
    v[12] = ctr[31:0];
    v[13] = ctr[63:32];
    v[14] = len;
    v[15] = fl;
    for (int r = 0; r < 7; r++) begin
      for (int k = 0; k < 8; k++) begin
        a = ia[k]; b = ib[k]; c = ic[k]; d = id[k];
        v[a] = v[a] + v[b] + m[2*k];
        v[d] = ror32(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror32(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + m[2*k+1];
        v[d] = ror32(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = ror32(v[b] ^ v[c], 7);
      end
      for (int i = 0; i < 16; i++) t[i] = m[pm[i]];
      m = t;
    end
    return v;
  endfunction

  function automatic w8_t b3_chain(w8_t cv, w16_t msg, logic [31:0] len,
                                   logic [63:0] ctr, logic [31:0] fl);
    w16_t v;
    w8_t  o;
    v = b3_compress(cv, msg, len, ctr, fl);
    for (int i = 0; i < 8; i++) o[i] = v[i] ^ v[i+8];
    return o;
  endfunction

  function automatic w8_t iv_words();
    w8_t o;
    for (int i = 0; i < 8; i++) o[i] = b3sh_pkg::InitVec[i];
    return o;
  endfunction

  function automatic logic [31:0] chunk_start_flag();
    return (blk_cnt == 0) ? b3sh_pkg::FlagChunkStart : 32'd0;
  endfunction

  function automatic void clear_chunk();
    hash_cv = iv_words();
    msg_buf = '{default: '0};
    buf_fill = 0;
    blk_cnt = 0;
  endfunction

  // Close the current chunk and merge its value up the subtree stack.
  function automatic void seal_chunk();
    w8_t cv;
    w16_t blk;
    logic [63:0] total;
    cv = b3_chain(hash_cv, msg_buf, 64, chunk_idx,
                  chunk_start_flag() | b3sh_pkg::FlagChunkEnd);
    total = chunk_idx + 64'd1;
    while (!total[0] && cv_depth > 0) begin
      cv_depth--;
      for (int i = 0; i < 8; i++) begin
        blk[i] = tree_vals[cv_depth*8+i];
        blk[i+8] = cv[i];
      end
      cv = b3_chain(iv_words(), blk, 64, 64'd0, b3sh_pkg::FlagParent);
      total = total >> 1;
    end
    // Drop the value when the stack is full.
    if (cv_depth < b3sh_pkg::StackSlots) begin
      for (int i = 0; i < 8; i++) tree_vals[cv_depth*8+i] = cv[i];
      cv_depth++;
    end
    chunk_idx = chunk_idx + 64'd1;
    clear_chunk();
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (buf_fill >= 64) begin
      if (blk_cnt >= 15) begin
        seal_chunk();
      end else begin
        hash_cv = b3_chain(hash_cv, msg_buf, 64, chunk_idx, chunk_start_flag());
        blk_cnt++;
        msg_buf = '{default: '0};
        buf_fill = 0;
      end
    end
    msg_buf[buf_fill >> 2] |= 32'(b) << ((buf_fill & 3) * 8);
    buf_fill++;
  endfunction

  function automatic void reset_hasher();
    clear_chunk();
    chunk_idx = '0;
    cv_depth = 0;
  endfunction

  // Absorb one accepted word; on the last word queue the expected digest beats.
  function automatic void predict_word(logic [31:0] data, logic [2:0] nb, logic last);
    w8_t cv;
    w16_t blk;
    w16_t v;
    logic [31:0] len, fl;
    logic [63:0] ctr;
    int n;
    digest_beat_t beat;
    n = (nb > 3'd4) ? 4 : int'(nb);
    for (int i = 0; i < n; i++) take_byte(data[8*i +: 8]);
    if (!last) return;
    cv = hash_cv;
    blk = msg_buf;
    len = buf_fill;
    ctr = chunk_idx;
    fl = chunk_start_flag() | b3sh_pkg::FlagChunkEnd;
    while (cv_depth > 0) begin
      cv = b3_chain(cv, blk, len, ctr, fl);
      cv_depth--;
      for (int i = 0; i < 8; i++) begin
        blk[i] = tree_vals[cv_depth*8+i];
        blk[i+8] = cv[i];
      end
      cv = iv_words();
      len = 64;
      ctr = '0;
      fl = b3sh_pkg::FlagParent;
    end
    v = b3_compress(cv, blk, len, 64'd0, fl | b3sh_pkg::FlagRoot);
    n = int'(out_words_reg);
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    for (int i = 0; i < n; i++) begin
      beat.word = (i < 8) ? (v[i] ^ v[i+8]) : (v[i] ^ cv[i-8]);
      beat.last = (i + 1 == n);
      digest_q.push_back(beat);
    end
    reset_hasher();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
    err_cnt++;
  endtask

  // Push one word through the input channel; hold the payload while stalled.
  task automatic send_word(logic [31:0] data, logic [2:0] nb, logic last);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_word_i <= data;
    valid_bytes_i <= nb;
    last_word_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(data, nb, last);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let the digest drain, give the block time to settle, then write the register.
  task automatic write_out_words(logic [4:0] val);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    out_words_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: compare each beat with the oldest expectation, stall at random.
  always @(posedge clk_i) begin
    digest_beat_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest beat", 32'd0, digest_word_o);
      end else begin
        exp_b = digest_q.pop_front();
        if (digest_word_o !== exp_b.word)
          report_mismatch("digest_word", exp_b.word, digest_word_o);
        if (last_digest_word_o !== exp_b.last)
          report_mismatch("last_digest_word", 32'(exp_b.last), 32'(last_digest_word_o));
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
  end

  // Watchdog: end the run when no beat moves for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    beat_moved = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i);
    if (!rst_ni || beat_moved) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("blake3_stream_hasher_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t directed [14] = '{
    '{-1, 32'h0000_0000, 3'd0, 1'b1},   // empty message, reset digest length
    '{ 0, 32'hffff_ffff, 3'd4, 1'b1},   // zero length acts as one word
    '{17, 32'h0000_0000, 3'd4, 1'b0},   // above sixteen acts as sixteen
    '{-1, 32'hffff_ffff, 3'd3, 1'b0},   // short word that is not last
    '{-1, 32'h1234_5678, 3'd5, 1'b0},   // byte counts above four
    '{-1, 32'ha5a5_a5a5, 3'd6, 1'b0},
    '{-1, 32'h5a5a_5a5a, 3'd7, 1'b1},
    '{16, 32'h6162_6364, 3'd1, 1'b1},
    '{ 1, 32'hdead_beef, 3'd2, 1'b1},
    '{31, 32'h0102_0304, 3'd4, 1'b0},
    '{-1, 32'hffff_ffff, 3'd0, 1'b1},   // empty last word after a full one
    '{ 8, 32'h8000_0001, 3'd4, 1'b0},
    '{-1, 32'h7fff_fffe, 3'd4, 1'b0},
    '{-1, 32'hffff_ffff, 3'd4, 1'b1}
  };

  initial begin
    int items;
    int msg_len;
    int msgs;
    logic [2:0] nb;
    bit last;
    out_words_reg = b3sh_pkg::DigestDefault;
    reset_hasher();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].reg_val >= 0) begin
        drop_valid();
        write_out_words(5'(directed[i].reg_val));
      end
      send_word(directed[i].data, directed[i].nbytes, directed[i].last);
    end

    // Random messages: mostly short, some across block bounds, one across a chunk.
    items = 0;
    msgs = 0;
    while (items < 364) begin
      drop_valid();
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: write_out_words(5'd1);
          1: write_out_words(5'd16);
          2: write_out_words(5'($urandom_range(0, 31)));
          default: write_out_words(5'($urandom_range(1, 16)));
        endcase
      end
      calm = (msgs >= 6 && msgs < 10);
      if (msgs == 3) msg_len = 260;            // up to 1040 bytes, may span two chunks and fold one stack level
      else if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(15, 40);
      else msg_len = $urandom_range(1, 12);
      for (int w = 0; w < msg_len; w++) begin
        last = (w == msg_len - 1);
        if (last || $urandom_range(0, 9) == 0) nb = 3'($urandom_range(0, 7));
        else nb = 3'd4;
        send_word($urandom, nb, last);
      end
      items += msg_len;
      msgs++;
    end
    calm = 1'b0;
    drop_valid();

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("blake3_stream_hasher_unit_tb: done, clean");
    end else begin
      $display("blake3_stream_hasher_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
